// ===== hdl/svp_pkg.sv =====
// Shared constants, types and table functions for the saturation vapour pressure block.
package svp_pkg;

  localparam int unsigned EXP_TABLE_BITS_DEF = 8;

  localparam int unsigned T_W  = 16;
  localparam int unsigned RH_W = 17;
  localparam int unsigned PS_W = 26;
  localparam int unsigned AH_W = 22;

  localparam logic [T_W-1:0]  T_LOW    = 16'd22315;
  localparam logic [T_W-1:0]  T_HIGH   = 16'd42315;
  localparam logic [RH_W-1:0] RH_ONE   = 17'd65536;
  localparam logic [PS_W-1:0] SAT26    = 26'h3FF_FFFF;
  localparam logic [AH_W-1:0] SAT22    = 22'h3F_FFFF;

  // Exponent divider: dividend, divisor and quotient magnitude widths.
  localparam int unsigned PROD1_W = 36;
  localparam int unsigned NUM1_W  = 52;
  localparam int unsigned DEN1_W  = 34;
  localparam int unsigned Q1_W    = 20;

  // Absolute humidity divider.
  localparam int unsigned NUM2_W = 53;
  localparam int unsigned DEN2_W = 31;
  localparam int unsigned Q2_W   = 23;

  localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
  localparam logic [63:0] LN2_Q31   = 64'd1488522236;

  typedef enum logic {
    FORMULA_MAGNUS = 1'b0,
    FORMULA_BUCK   = 1'b1
  } formula_e;

  typedef enum logic {
    REG_FORMULA_SELECT    = 1'b0,
    REG_RELATIVE_HUMIDITY = 1'b1
  } reg_e;

  // Long division used only while the constant table is elaborated.
  function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] q;
    logic [63:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Entry k of the 2^(k/2^bits) table in Q30, from a Taylor series of exp(k*ln2/2^bits).
  function automatic logic [31:0] exp_entry(input int unsigned k, input int unsigned bits);
    logic [63:0] z;
    logic [63:0] sum;
    logic [63:0] term;
    z    = (64'(k) * LN2_Q31 + (64'd1 << (bits - 1))) >> bits;
    sum  = 64'd1 << 31;
    term = 64'd1 << 31;
    for (int unsigned j = 1; j < 40; j++) begin
      if (term != '0) begin
        term = udiv64((term * z) >> 31, 64'(j));
        sum  = sum + term;
      end
    end
    if (k == (32'd1 << bits)) begin
      return 32'h8000_0000;
    end
    return 32'((sum + 64'd1) >> 1);
  endfunction

endpackage

// ===== hdl/svp_in_if.sv =====
// Input channel carrying one temperature per beat.
interface svp_in_if;
  import svp_pkg::*;
  logic           valid;
  logic           ready;
  logic [T_W-1:0] temperature_centik;
  modport source (output valid, output temperature_centik, input ready);
  modport sink (input valid, input temperature_centik, output ready);
endinterface

// ===== hdl/svp_out_if.sv =====
// Output channel carrying the three humidity results per beat.
interface svp_out_if;
  import svp_pkg::*;
  logic            valid;
  logic            ready;
  logic [PS_W-1:0] saturation_pressure;
  logic [PS_W-1:0] partial_pressure;
  logic [AH_W-1:0] absolute_humidity;
  modport source (output valid, output saturation_pressure, output partial_pressure,
                  output absolute_humidity, input ready);
  modport sink (input valid, input saturation_pressure, input partial_pressure,
                input absolute_humidity, output ready);
endinterface

// ===== hdl/svp_div.sv =====
// Pipelined restoring divider, one quotient bit per register stage.
module svp_div #(
  parameter int unsigned NUM_W = 52,
  parameter int unsigned DEN_W = 34,
  parameter int unsigned Q_W   = 20,
  parameter int unsigned SB_W  = 17
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [SB_W-1:0]  sb_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quo_o,
  output logic [SB_W-1:0]  sb_o
);

  localparam int unsigned CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

  logic [Q_W-1:0]   v_q;
  logic [NUM_W-1:0] rem_q [Q_W];
  logic [NUM_W-1:0] rem_d [Q_W];
  logic [DEN_W-1:0] den_q [Q_W];
  logic [DEN_W-1:0] den_d [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];
  logic [Q_W-1:0]   quo_d [Q_W];
  logic [SB_W-1:0]  sb_q  [Q_W];
  logic [SB_W-1:0]  sb_d  [Q_W];

  // Stage g decides quotient bit Q_W-1-g; the caller guarantees num < den * 2^Q_W.
  always_comb begin
    logic [NUM_W-1:0] rsel;
    logic [DEN_W-1:0] dsel;
    logic [Q_W-1:0]   qsel;
    logic [SB_W-1:0]  ssel;
    logic [CW-1:0]    rin;
    logic [CW-1:0]    sh;
    for (int g = 0; g < Q_W; g++) begin
      if (g == 0) begin
        rsel = num_i;
        dsel = den_i;
        qsel = '0;
        ssel = sb_i;
      end else begin
        rsel = rem_q[g-1];
        dsel = den_q[g-1];
        qsel = quo_q[g-1];
        ssel = sb_q[g-1];
      end
      rin = CW'(rsel);
      sh  = CW'(dsel) << (Q_W - 1 - g);
      if (rin >= sh) begin
        rem_d[g] = NUM_W'(rin - sh);
        quo_d[g] = qsel | (Q_W'(1) << (Q_W - 1 - g));
      end else begin
        rem_d[g] = rsel;
        quo_d[g] = qsel;
      end
      den_d[g] = dsel;
      sb_d[g]  = ssel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[Q_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g < Q_W; g++) begin
        rem_q[g] <= rem_d[g];
        den_q[g] <= den_d[g];
        quo_q[g] <= quo_d[g];
        sb_q[g]  <= sb_d[g];
      end
    end
  end

  assign valid_o = v_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign sb_o    = sb_q[Q_W-1];

endmodule

// ===== hdl/svp_exp.sv =====
// Exponent to saturation pressure: base-2 conversion, table interpolation and scaling.
module svp_exp #(
  parameter int unsigned TAB_BITS = svp_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  svp_pkg::formula_e         formula_i,
  input  logic                      valid_i,
  input  logic signed [20:0]        x_i,
  input  logic [svp_pkg::T_W-1:0]   t_i,
  output logic                      valid_o,
  output logic [svp_pkg::PS_W-1:0]  ps_o,
  output logic [svp_pkg::T_W-1:0]   t_o
);
  import svp_pkg::*;

  localparam int unsigned NST   = 7;
  localparam int unsigned TAB_N = (1 << TAB_BITS) + 1;
  localparam int unsigned RW    = 16 - TAB_BITS;
  localparam int unsigned DRW   = 32 + RW;

  logic [31:0] tab [TAB_N];

  for (genvar k = 0; k < TAB_N; k++) begin : g_tab
    localparam logic [31:0] ENTRY = exp_entry(32'(k), TAB_BITS);
    assign tab[k] = ENTRY;
  end

  logic [NST-1:0] v_q;
  logic [T_W-1:0] t_q [NST];

  logic signed [52:0] xl_q;
  logic signed [6:0]  n1_q, n2_q, n3_q, n4_q;
  logic [15:0]        f1_q;
  logic [31:0]        e0_q, d_q, e03_q, m_q;
  logic [RW-1:0]      r_q;
  logic [DRW-1:0]     dr_q;
  logic signed [7:0]  s_q;
  logic [47:0]        am_q;
  logic [PS_W-1:0]    ps_q;

  logic signed [52:0] y_full;
  logic [TAB_BITS:0]  idx0, idx1;
  logic [31:0]        e0, e1;
  logic [15:0]        coef;
  logic [PS_W-1:0]    ps_d;

  assign y_full = xl_q + 53'sd536870912;
  assign idx0   = {1'b0, f1_q[15 -: TAB_BITS]};
  assign idx1   = idx0 + 1'b1;
  assign e0     = tab[idx0];
  assign e1     = tab[idx1];
  assign coef   = (formula_i == FORMULA_BUCK) ? 16'd61121 : 16'd61120;

  // Final scaling by 2^(n-30) with rounding half up.
  always_comb begin
    logic [63:0] rnd;
    logic [63:0] p64;
    rnd  = '0;
    p64  = '0;
    ps_d = '0;
    if (s_q <= 8'sd0) begin
      ps_d = SAT26;
    end else if (s_q >= 8'sd63) begin
      ps_d = '0;
    end else begin
      rnd  = 64'(am_q) + (64'd1 << 6'(s_q - 8'sd1));
      p64  = rnd >> 6'(s_q);
      ps_d = (p64 > 64'(SAT26)) ? SAT26 : p64[PS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[NST-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q[0] <= t_i;
      for (int i = 1; i < NST; i++) begin
        t_q[i] <= t_q[i-1];
      end
      xl_q  <= 53'(x_i) * $signed({21'd0, LOG2E_Q30});
      n1_q  <= y_full[52:46];
      f1_q  <= y_full[45:30];
      n2_q  <= n1_q;
      e0_q  <= e0;
      d_q   <= (e1 > e0) ? e1 - e0 : 32'd0;
      r_q   <= f1_q[RW-1:0];
      n3_q  <= n2_q;
      e03_q <= e0_q;
      dr_q  <= DRW'(d_q) * DRW'(r_q);
      n4_q  <= n3_q;
      m_q   <= e03_q + 32'(dr_q >> RW);
      s_q   <= 8'sd30 - 8'(n4_q);
      am_q  <= 48'(coef) * 48'(m_q);
      ps_q  <= ps_d;
    end
  end

  assign valid_o = v_q[NST-1];
  assign ps_o    = ps_q;
  assign t_o     = t_q[NST-1];

endmodule

// ===== hdl/saturation_vapour_pressure_core.sv =====
// Top level: one beat per cycle sustained while the output side keeps taking results.
// Stages: four front stages, a 20-stage exponent divider, seven exponent stages,
// four humidity stages, a 23-stage density divider and the output register.
// The whole pipeline advances whenever the output register is empty or being taken.
// Reset (rst_ni low, asynchronous) clears all valid bits and the configuration registers.
module saturation_vapour_pressure_core #(
  parameter int unsigned EXP_TABLE_BITS = svp_pkg::EXP_TABLE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  svp_in_if.sink      in_if,
  svp_out_if.source   out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import svp_pkg::*;

  formula_e        formula_q;
  logic [RH_W-1:0] rh_q;
  logic            en;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      formula_q <= FORMULA_MAGNUS;
      rh_q      <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_e'(paddr[2]))
        REG_FORMULA_SELECT:    formula_q <= formula_e'(pwdata[0]);
        REG_RELATIVE_HUMIDITY: rh_q      <= pwdata[RH_W-1:0];
        default:               ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_e'(paddr[2]))
      REG_FORMULA_SELECT:    prdata = 32'(formula_q);
      REG_RELATIVE_HUMIDITY: prdata = 32'(rh_q);
      default:               prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  logic out_valid_q;
  assign en          = !out_valid_q || out_if.ready;
  assign in_if.ready = en;

  logic buck;
  assign buck = (formula_q == FORMULA_BUCK);

  // Front stages: clamp, Celsius offset, dividend and divisor of the exponent.
  logic           f1_v_q, f2_v_q, f3_v_q, f4_v_q;
  logic [T_W-1:0] f1_t_q, f2_t_q, f3_t_q, f4_t_q;
  logic [T_W-1:0] t_clamp;

  always_comb begin
    if (in_if.temperature_centik < T_LOW) begin
      t_clamp = T_LOW;
    end else if (in_if.temperature_centik > T_HIGH) begin
      t_clamp = T_HIGH;
    end else begin
      t_clamp = in_if.temperature_centik;
    end
  end

  logic signed [17:0] tc_w;
  logic signed [15:0] tc;
  logic signed [24:0] a_s;
  logic signed [17:0] base_s;

  assign tc_w   = $signed({2'b00, f1_t_q}) - 18'sd27315;
  assign tc     = tc_w[15:0];
  assign a_s    = 25'sd4379991 - 25'sd10 * 25'(tc);
  assign base_s = 18'(tc) + (buck ? 18'sd25714 : 18'sd24312);

  logic                f2_neg_q, f3_neg_q, f4_neg_q;
  logic [13:0]         f2_abs_q;
  logic [22:0]         f2_a_q;
  logic [15:0]         f2_base_q;
  logic [PROD1_W-1:0]  f3_prod_q;
  logic [DEN1_W-1:0]   f3_den_q, f4_den_q;
  logic [NUM1_W-1:0]   f4_num_q;
  logic [15:0]         tc_abs;

  assign tc_abs = tc[15] ? 16'(-tc) : 16'(tc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
      f4_v_q <= 1'b0;
    end else if (en) begin
      f1_v_q <= in_if.valid;
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
      f4_v_q <= f3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_t_q    <= t_clamp;
      f2_t_q    <= f1_t_q;
      f2_neg_q  <= tc[15];
      f2_abs_q  <= tc_abs[13:0];
      f2_a_q    <= a_s[22:0];
      f2_base_q <= base_s[15:0];
      f3_t_q    <= f2_t_q;
      f3_neg_q  <= f2_neg_q;
      f3_prod_q <= buck ? PROD1_W'(f2_a_q) * PROD1_W'(f2_abs_q)
                        : PROD1_W'(f2_abs_q) * 36'd1762;
      f3_den_q  <= buck ? DEN1_W'(f2_base_q) * 34'd234500
                        : DEN1_W'(f2_base_q) * 34'd100;
      f4_t_q    <= f3_t_q;
      f4_neg_q  <= f3_neg_q;
      f4_num_q  <= {f3_prod_q, 16'd0} + NUM1_W'(f3_den_q >> 1);
      f4_den_q  <= f3_den_q;
    end
  end

  // Exponent magnitude, rounded half away from zero.
  logic            d1_v;
  logic [Q1_W-1:0] d1_q;
  logic [T_W:0]    d1_sb;

  svp_div #(
    .NUM_W (NUM1_W),
    .DEN_W (DEN1_W),
    .Q_W   (Q1_W),
    .SB_W  (T_W + 1)
  ) u_div_exp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f4_v_q),
    .num_i   (f4_num_q),
    .den_i   (f4_den_q),
    .sb_i    ({f4_neg_q, f4_t_q}),
    .valid_o (d1_v),
    .quo_o   (d1_q),
    .sb_o    (d1_sb)
  );

  logic signed [20:0] x;
  assign x = d1_sb[T_W] ? -$signed({1'b0, d1_q}) : $signed({1'b0, d1_q});

  logic            e_v;
  logic [PS_W-1:0] e_ps;
  logic [T_W-1:0]  e_t;

  svp_exp #(
    .TAB_BITS (EXP_TABLE_BITS)
  ) u_exp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .formula_i (formula_q),
    .valid_i   (d1_v),
    .x_i       (x),
    .t_i       (d1_sb[T_W-1:0]),
    .valid_o   (e_v),
    .ps_o      (e_ps),
    .t_o       (e_t)
  );

  // Humidity stages: partial pressure, then the density dividend and divisor.
  logic [RH_W-1:0]   rh_c;
  logic              h1_v_q, h2_v_q, h3_v_q, h4_v_q;
  logic [T_W-1:0]    h1_t_q, h2_t_q;
  logic [PS_W-1:0]   h1_ps_q, h2_ps_q, h3_ps_q, h4_ps_q;
  logic [42:0]       h1_full_q;
  logic [42:0]       pp_rnd;
  logic [PS_W-1:0]   h2_pp_q, h3_pp_q, h4_pp_q;
  logic [NUM2_W-1:0] h3_num_q, h4_num_q;
  logic [DEN2_W-1:0] h3_den_q, h4_den_q;

  assign rh_c   = (rh_q > RH_ONE) ? RH_ONE : rh_q;
  assign pp_rnd = h1_full_q + 43'd32768;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h1_v_q <= 1'b0;
      h2_v_q <= 1'b0;
      h3_v_q <= 1'b0;
      h4_v_q <= 1'b0;
    end else if (en) begin
      h1_v_q <= e_v;
      h2_v_q <= h1_v_q;
      h3_v_q <= h2_v_q;
      h4_v_q <= h3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h1_t_q    <= e_t;
      h1_ps_q   <= e_ps;
      h1_full_q <= 43'(e_ps) * 43'(rh_c);
      h2_t_q    <= h1_t_q;
      h2_ps_q   <= h1_ps_q;
      h2_pp_q   <= pp_rnd[42] ? SAT26 : pp_rnd[41:16];
      h3_ps_q   <= h2_ps_q;
      h3_pp_q   <= h2_pp_q;
      h3_num_q  <= NUM2_W'(h2_pp_q) * 53'd100000000;
      h3_den_q  <= DEN2_W'(h2_t_q) * 31'd46151;
      h4_ps_q   <= h3_ps_q;
      h4_pp_q   <= h3_pp_q;
      h4_num_q  <= h3_num_q + NUM2_W'(h3_den_q >> 1);
      h4_den_q  <= h3_den_q;
    end
  end

  logic               d2_v;
  logic [Q2_W-1:0]    d2_q;
  logic [2*PS_W-1:0]  d2_sb;

  svp_div #(
    .NUM_W (NUM2_W),
    .DEN_W (DEN2_W),
    .Q_W   (Q2_W),
    .SB_W  (2 * PS_W)
  ) u_div_ah (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (h4_v_q),
    .num_i   (h4_num_q),
    .den_i   (h4_den_q),
    .sb_i    ({h4_ps_q, h4_pp_q}),
    .valid_o (d2_v),
    .quo_o   (d2_q),
    .sb_o    (d2_sb)
  );

  // Output register holds a beat until it is taken.
  logic [PS_W-1:0] out_ps_q, out_pp_q;
  logic [AH_W-1:0] out_ah_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && d2_v) begin
      out_ps_q <= d2_sb[2*PS_W-1:PS_W];
      out_pp_q <= d2_sb[PS_W-1:0];
      out_ah_q <= (d2_q > Q2_W'(SAT22)) ? SAT22 : d2_q[AH_W-1:0];
    end
  end

  assign out_if.valid               = out_valid_q;
  assign out_if.saturation_pressure = out_ps_q;
  assign out_if.partial_pressure    = out_pp_q;
  assign out_if.absolute_humidity   = out_ah_q;

endmodule

// ===== tb/sv/tb_saturation_vapour_pressure_core.sv =====
// Testbench for saturation_vapour_pressure_core: streams temperatures, predicts the three results.
module tb_saturation_vapour_pressure_core;
  timeunit 1ns;
  timeprecision 1ps;
  import svp_pkg::*;

  localparam int unsigned TAB_BITS = EXP_TABLE_BITS_DEF;
  localparam int unsigned WATCHDOG_LIMIT = 5000;

  typedef struct packed {
    logic [PS_W-1:0] sat_p;
    logic [PS_W-1:0] part_p;
    logic [AH_W-1:0] abs_h;
  } humidity_t;

  logic clk_i;
  logic rst_ni;
  logic psel, penable, pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  svp_in_if  in_ch ();
  svp_out_if out_ch ();

  saturation_vapour_pressure_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (in_ch.sink),
    .out_if  (out_ch.source),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  logic [T_W-1:0] pending_temps[$];
  humidity_t      expected_results[$];
  longint unsigned exp2_q30[0:(1 << TAB_BITS)];
  formula_e       cfg_formula;
  logic [RH_W-1:0] cfg_rh;
  int unsigned    errors;
  int unsigned    hold_cycles;
  int unsigned    quiet_cycles;
  bit             no_idle;
  bit             temp_taken;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Fractional powers of two in Q30 from a Taylor series of exp in Q31.
  initial begin
    longint unsigned z, sum, term;
    for (int k = 0; k <= (1 << TAB_BITS); k++) begin
      z = (longint'(k) * 64'd1488522236 + (64'd1 << (TAB_BITS - 1))) >> TAB_BITS;
      sum = 64'd1 << 31;
      term = 64'd1 << 31;
      for (int j = 1; j < 40 && term != 0; j++) begin
        term = ((term * z) >> 31) / j;
        sum += term;
      end
      exp2_q30[k] = (sum + 1) >> 1;
    end
    exp2_q30[1 << TAB_BITS] = 64'd1 << 31;
  end

  function automatic longint round_div(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  function automatic humidity_t predict_humidity(logic [T_W-1:0] temp_raw);
    longint t, tc, x, nexp, s;
    longint unsigned v, f, idx, rem, d, m, a, ps, pp, rh, den, ah;
    humidity_t r;
    t = temp_raw;
    if (t < T_LOW) t = T_LOW;
    if (t > T_HIGH) t = T_HIGH;
    tc = t - 27315;
    if (cfg_formula == FORMULA_BUCK) begin
      x = round_div((64'sd4379991 - 10 * tc) * tc * 65536, 64'sd234500 * (25714 + tc));
      a = 61121;
    end else begin
      x = round_div(64'sd1762 * tc * 65536, 64'sd100 * (24312 + tc));
      a = 61120;
    end
    // Exponent in base two, offset by 1024 so that it stays positive.
    v = x * 64'sd1549082005 + (64'sd1 << 56) + (64'sd1 << 29);
    v = v >> 30;
    nexp = longint'(v >> 16) - 1024;
    f = v & 64'hFFFF;
    idx = f >> (16 - TAB_BITS);
    rem = f & ((64'd1 << (16 - TAB_BITS)) - 1);
    d = exp2_q30[idx + 1] > exp2_q30[idx] ? exp2_q30[idx + 1] - exp2_q30[idx] : 0;
    m = exp2_q30[idx] + ((d * rem) >> (16 - TAB_BITS));
    s = 30 - nexp;
    if (s <= 0) ps = SAT26;
    else if (s >= 63) ps = 0;
    else begin
      ps = (a * m + (64'd1 << (s - 1))) >> s;
      if (ps > SAT26) ps = SAT26;
    end
    rh = cfg_rh > RH_ONE ? RH_ONE : cfg_rh;
    pp = (ps * rh + (64'd1 << 15)) >> 16;
    if (pp > SAT26) pp = SAT26;
    den = 64'd46151 * t;
    ah = (pp * 64'd100000000 + den / 2) / den;
    if (ah > SAT22) ah = SAT22;
    r.sat_p = ps[PS_W-1:0];
    r.part_p = pp[PS_W-1:0];
    r.abs_h = ah[AH_W-1:0];
    return r;
  endfunction

  // Temperature driver.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.temperature_centik <= '0;
      temp_taken = 1'b0;
    end else if (!in_ch.valid || temp_taken) begin
      temp_taken = 1'b0;
      if (pending_temps.size() > 0 && (no_idle || $urandom_range(99) >= 7)) begin
        in_ch.valid <= 1'b1;
        in_ch.temperature_centik <= pending_temps.pop_front();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver with random stalls and the long hold-off.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= no_idle || $urandom_range(99) >= 7;
    end
  end

  // Monitor: predicts on input beats, checks on output beats.
  always @(posedge clk_i) begin
    humidity_t got, want;
    bit        beat_seen;
    if (rst_ni) begin
      beat_seen = 1'b0;
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_humidity(in_ch.temperature_centik));
        temp_taken = 1'b1;
        beat_seen = 1'b1;
      end
      if (out_ch.valid && out_ch.ready) begin
        beat_seen = 1'b1;
        got = {out_ch.saturation_pressure, out_ch.partial_pressure, out_ch.absolute_humidity};
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, expected none, actual %h", $time, got);
        end else begin
          want = expected_results.pop_front();
          if (got.sat_p !== want.sat_p) begin
            errors++;
            $display("%0t: saturation_pressure expected %0d actual %0d", $time,
                     want.sat_p, got.sat_p);
          end
          if (got.part_p !== want.part_p) begin
            errors++;
            $display("%0t: partial_pressure expected %0d actual %0d", $time,
                     want.part_p, got.part_p);
          end
          if (got.abs_h !== want.abs_h) begin
            errors++;
            $display("%0t: absolute_humidity expected %0d actual %0d", $time,
                     want.abs_h, got.abs_h);
          end
        end
      end
      quiet_cycles <= beat_seen ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_saturation_vapour_pressure_core: done, errors");
        $finish;
      end
    end
  end

  task automatic reg_write(reg_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(idx) << 2;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_FORMULA_SELECT) cfg_formula = formula_e'(value[0]);
    else cfg_rh = value[RH_W-1:0];
  endtask

  task automatic drain();
    while (pending_temps.size() > 0 || in_ch.valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (70) @(posedge clk_i);
  endtask

  task automatic set_config(formula_e fsel, logic [RH_W-1:0] rh);
    drain();
    // Upper bits of the select word carry noise that the register drops.
    reg_write(REG_FORMULA_SELECT, {31'($urandom), 1'(fsel)});
    reg_write(REG_RELATIVE_HUMIDITY, {15'($urandom), rh});
  endtask

  task automatic push_random(int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) == 0) pending_temps.push_back(16'($urandom));
      else pending_temps.push_back(16'($urandom_range(T_HIGH, T_LOW)));
    end
  endtask

  initial begin
    logic [T_W-1:0] edge_temps[$];
    errors = 0;
    hold_cycles = 0;
    quiet_cycles = 0;
    no_idle = 1'b0;
    cfg_formula = FORMULA_MAGNUS;
    cfg_rh = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset configuration first: Magnus with zero humidity.
    edge_temps = '{16'd0, 16'd22314, T_LOW, 16'd22316, 16'd27315, 16'd27314, 16'd27316,
                   16'd37315, T_HIGH, 16'd42316, 16'hFFFF, 16'hAAAA, 16'h5555};
    foreach (edge_temps[i]) pending_temps.push_back(edge_temps[i]);
    set_config(FORMULA_MAGNUS, RH_ONE);
    foreach (edge_temps[i]) pending_temps.push_back(edge_temps[i]);
    set_config(FORMULA_BUCK, 17'h1FFFF);
    foreach (edge_temps[i]) pending_temps.push_back(edge_temps[i]);

    set_config(FORMULA_MAGNUS, 17'($urandom_range(65536)));
    hold_cycles = 300;
    push_random(150);
    set_config(FORMULA_BUCK, RH_ONE);
    no_idle = 1'b1;
    push_random(150);
    set_config(FORMULA_BUCK, 17'($urandom));
    no_idle = 1'b0;
    push_random(150);
    set_config(FORMULA_MAGNUS, 17'd0);
    push_random(60);
    set_config(FORMULA_MAGNUS, 17'd65537);
    push_random(60);
    drain();

    if (errors == 0) begin
      $display("tb_saturation_vapour_pressure_core: done, clean");
    end else begin
      $display("tb_saturation_vapour_pressure_core: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/svp_pkg.sv
hdl/svp_in_if.sv
hdl/svp_out_if.sv
hdl/svp_div.sv
hdl/svp_exp.sv
hdl/saturation_vapour_pressure_core.sv
tb/sv/tb_saturation_vapour_pressure_core.sv
